[rtl/core/hdsr_pkg.sv]
package hdsr_pkg;

    // request kinds
    localparam logic [1:0] REQ_CREATE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_WRITE   = 2'd3;

    // field select of a write
    localparam logic FIELD_A = 1'b0;
    localparam logic FIELD_B = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEAD  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOIDS = 2'd3;

    // request beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         obj_id;
        logic               field_sel;
        logic signed [31:0] value;
    } req_t;

    // result beat
    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         new_id;
        logic signed [31:0] a_value;
        logic signed [31:0] b_value;
        logic [8:0]         live_count;
    } rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_CHECK,
        S_MOVE,
        S_KILL,
        S_REC
    } state_t;

endpackage

[rtl/core/hdsr_ram.sv]
module hdsr_ram import hdsr_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/handle_table_dense_swap_remove_top.sv]
// channel   | ports              | handshake
// ----------+--------------------+------------------------------------------
// request   | start, busy, req   | beat taken on clk rise with start & !busy
// result    | done, rsp          | beat valid for the one cycle done is high
//
// create passes S_CREATE between accept and done; read and write pass
// S_CHECK and S_REC; a failed lookup ends in S_CHECK; destroy passes S_CHECK,
// S_MOVE when a record is moved, and S_KILL. the sequencer visits the registered
// read ports of the id, owner and record memories one dependent access a step.
// the id table needs no clearing pass: ids at or above the next free id
// read as dead. reset leaves the block idle with no records and no ids.
// the receiver cannot stall; a new request may be taken while done is high.
module handle_table_dense_swap_remove_top import hdsr_pkg::*; #(
    parameter int MAX_OBJECTS = 256,
    parameter int MAX_IDS     = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int SLOT_W = $clog2(MAX_OBJECTS);
    localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
    localparam int ID_W   = $clog2(MAX_IDS);
    localparam int NID_W  = $clog2(MAX_IDS + 1);
    localparam int CMP_W  = (NID_W > 10) ? NID_W : 10;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic               id_ok_reg, id_ok_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NID_W-1:0]   nfid_reg, nfid_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CMP_W-1:0]   in_id_w;
    logic [CMP_W-1:0]   held_id_w;
    logic [CMP_W-1:0]   nfid_w;
    logic [CNT_W-1:0]   slot_p1;
    logic [CNT_W-1:0]   last_c;
    logic [SLOT_W-1:0]  last_slot;
    logic [SLOT_W-1:0]  found_slot;
    logic [CNT_W-1:0]   found_m1;
    logic               found_live;

    // memory ports
    logic               map_we;
    logic [ID_W-1:0]    map_waddr;
    logic [CNT_W-1:0]   map_wdata;
    logic [ID_W-1:0]    map_raddr;
    logic [CNT_W-1:0]   map_rdata;
    logic               own_we;
    logic [SLOT_W-1:0]  own_waddr;
    logic [ID_W-1:0]    own_wdata;
    logic [SLOT_W-1:0]  own_raddr;
    logic [ID_W-1:0]    own_rdata;
    logic               fa_we;
    logic [31:0]        fa_wdata;
    logic               fb_we;
    logic [31:0]        fb_wdata;
    logic [SLOT_W-1:0]  rec_waddr;
    logic [SLOT_W-1:0]  rec_raddr;
    logic [31:0]        fa_rdata;
    logic [31:0]        fb_rdata;

    // id to slot+1, owner of each slot, record fields
    hdsr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_IDS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    hdsr_ram #(.WIDTH(ID_W), .DEPTH(MAX_OBJECTS)) u_owner (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    hdsr_ram #(.WIDTH(32), .DEPTH(MAX_OBJECTS)) u_field_a (
        .clk   (clk),
        .we    (fa_we),
        .waddr (rec_waddr),
        .wdata (fa_wdata),
        .raddr (rec_raddr),
        .rdata (fa_rdata)
    );

    hdsr_ram #(.WIDTH(32), .DEPTH(MAX_OBJECTS)) u_field_b (
        .clk   (clk),
        .we    (fb_we),
        .waddr (rec_waddr),
        .wdata (fb_wdata),
        .raddr (rec_raddr),
        .rdata (fb_rdata)
    );

    // shared index arithmetic
    assign in_id_w    = CMP_W'(req.obj_id);
    assign held_id_w  = CMP_W'(req_reg.obj_id);
    assign nfid_w     = CMP_W'(nfid_reg);
    assign slot_p1    = CNT_W'(slot_reg) + CNT_W'(1);
    assign last_c     = cnt_reg - CNT_W'(1);
    assign last_slot  = last_c[SLOT_W-1:0];
    assign found_m1   = map_rdata - CNT_W'(1);
    assign found_slot = found_m1[SLOT_W-1:0];
    assign found_live = id_ok_reg && (map_rdata != '0) && (map_rdata <= cnt_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            nfid_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nfid_reg  <= nfid_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        id_ok_reg <= id_ok_next;
        slot_reg  <= slot_next;
        rsp_reg   <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        id_ok_next = id_ok_reg;
        slot_next  = slot_reg;
        cnt_next   = cnt_reg;
        nfid_next  = nfid_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        map_we    = 1'b0;
        map_waddr = held_id_w[ID_W-1:0];
        map_wdata = '0;
        map_raddr = in_id_w[ID_W-1:0];
        own_we    = 1'b0;
        own_waddr = slot_reg;
        own_wdata = own_rdata;
        own_raddr = last_slot;
        fa_we     = 1'b0;
        fa_wdata  = fa_rdata;
        fb_we     = 1'b0;
        fb_wdata  = fb_rdata;
        rec_waddr = slot_reg;
        rec_raddr = slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                // map lookup issued at accept
                if (start)
                begin
                    req_next   = req;
                    id_ok_next = in_id_w < nfid_w;
                    if (req.req_type == REQ_CREATE)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CREATE:
            begin
                state_next          = S_IDLE;
                done_next           = 1'b1;
                rsp_next.new_id     = '0;
                rsp_next.a_value    = '0;
                rsp_next.b_value    = '0;
                rsp_next.live_count = 9'(cnt_reg);
                if (nfid_reg == NID_W'(MAX_IDS))
                begin
                    rsp_next.status = ST_NOIDS;
                end
                else if (cnt_reg == CNT_W'(MAX_OBJECTS))
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    // append zeroed record owned by the next id
                    rec_waddr           = cnt_reg[SLOT_W-1:0];
                    fa_we               = 1'b1;
                    fa_wdata            = '0;
                    fb_we               = 1'b1;
                    fb_wdata            = '0;
                    own_we              = 1'b1;
                    own_waddr           = cnt_reg[SLOT_W-1:0];
                    own_wdata           = nfid_reg[ID_W-1:0];
                    map_we              = 1'b1;
                    map_waddr           = nfid_reg[ID_W-1:0];
                    map_wdata           = cnt_reg + CNT_W'(1);
                    cnt_next            = cnt_reg + CNT_W'(1);
                    nfid_next           = nfid_reg + NID_W'(1);
                    rsp_next.status     = ST_OK;
                    rsp_next.new_id     = 10'(nfid_reg);
                    rsp_next.live_count = 9'(cnt_reg + CNT_W'(1));
                end
            end

            S_CHECK:
            begin
                slot_next = found_slot;
                rec_raddr = (req_reg.req_type == REQ_DESTROY) ? last_slot : found_slot;
                if (!found_live)
                begin
                    state_next          = S_IDLE;
                    done_next           = 1'b1;
                    rsp_next.status     = ST_DEAD;
                    rsp_next.new_id     = '0;
                    rsp_next.a_value    = '0;
                    rsp_next.b_value    = '0;
                    rsp_next.live_count = 9'(cnt_reg);
                end
                else if (req_reg.req_type == REQ_DESTROY)
                begin
                    // last record is dropped, others move the last one in
                    state_next = (found_slot == last_slot) ? S_KILL : S_MOVE;
                end
                else
                begin
                    state_next = S_REC;
                end
            end

            S_MOVE:
            begin
                // last record into the freed slot, remap its owner
                state_next = S_KILL;
                fa_we      = 1'b1;
                fb_we      = 1'b1;
                own_we     = 1'b1;
                map_we     = 1'b1;
                map_waddr  = own_rdata;
                map_wdata  = slot_p1;
            end

            S_KILL:
            begin
                state_next          = S_IDLE;
                done_next           = 1'b1;
                map_we              = 1'b1;
                map_waddr           = held_id_w[ID_W-1:0];
                map_wdata           = '0;
                cnt_next            = last_c;
                rsp_next.status     = ST_OK;
                rsp_next.new_id     = '0;
                rsp_next.a_value    = '0;
                rsp_next.b_value    = '0;
                rsp_next.live_count = 9'(last_c);
            end

            S_REC:
            begin
                state_next          = S_IDLE;
                done_next           = 1'b1;
                rsp_next.status     = ST_OK;
                rsp_next.new_id     = '0;
                rsp_next.a_value    = $signed(fa_rdata);
                rsp_next.b_value    = $signed(fb_rdata);
                rsp_next.live_count = 9'(cnt_reg);
                // write one field, result shows the new value
                if (req_reg.req_type == REQ_WRITE)
                begin
                    if (req_reg.field_sel == FIELD_A)
                    begin
                        fa_we            = 1'b1;
                        fa_wdata         = req_reg.value;
                        rsp_next.a_value = req_reg.value;
                    end
                    else
                    begin
                        fb_we            = 1'b1;
                        fb_wdata         = req_reg.value;
                        rsp_next.b_value = req_reg.value;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a result beat only leaves while the sequencer is back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result beat while busy");

    // record count stays within the store
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OBJECTS))
        else $error("record count out of range");

    // a destroy removes exactly one record
    a_kill_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KILL |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("destroy did not drop one record");

    // ids are only ever handed out upward, one per successful create
    a_nfid_step: assert property (@(posedge clk) disable iff (!rst_n)
        nfid_reg != $past(nfid_reg) |-> nfid_reg == $past(nfid_reg) + NID_W'(1)
            && cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("id counter moved without a create");

endmodule

[verif/tb_handle_table_dense_swap_remove_top.sv]
`timescale 1ns / 1ps

module tb_handle_table_dense_swap_remove_top;
    import hdsr_pkg::*;

    localparam int NUM_SLOTS    = 256;
    localparam int NUM_IDS      = 1024;
    localparam int RANDOM_ITEMS = 900;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

    typedef struct {
        req_t stim;
        bit   typed;
        rsp_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // mirror of the handle table
    bit [8:0]           id_slot    [NUM_IDS];
    bit [9:0]           slot_owner [NUM_SLOTS];
    logic signed [31:0] rec_a      [NUM_SLOTS];
    logic signed [31:0] rec_b      [NUM_SLOTS];
    bit [8:0]           live_cnt;
    bit [10:0]          next_id;

    rsp_t awaited_rsp_q [$];
    int   mismatches;
    int   burst_left;

    handle_table_dense_swap_remove_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // apply one request to the mirror and return the beat it should produce
    function automatic rsp_t table_update(req_t r);
        rsp_t     o;
        bit [8:0] s;
        bit [8:0] s_m1;
        bit [8:0] l_m1;
        bit [7:0] slot;
        bit [7:0] last;
        o = '0;
        if (r.req_type == REQ_CREATE)
        begin
            if (next_id >= NUM_IDS)
                o.status = ST_NOIDS;
            else if (live_cnt >= NUM_SLOTS)
                o.status = ST_FULL;
            else
            begin
                slot = live_cnt[7:0];
                rec_a[slot] = '0;
                rec_b[slot] = '0;
                slot_owner[slot] = next_id[9:0];
                id_slot[next_id[9:0]] = live_cnt + 9'd1;
                o.new_id = next_id[9:0];
                live_cnt++;
                next_id++;
            end
        end
        else
        begin
            s = id_slot[r.obj_id];
            if (s == 0 || s > live_cnt)
                o.status = ST_DEAD;
            else
            begin
                s_m1 = s - 9'd1;
                slot = s_m1[7:0];
                if (r.req_type == REQ_DESTROY)
                begin
                    // swap-remove: last record fills the hole
                    l_m1 = live_cnt - 9'd1;
                    last = l_m1[7:0];
                    if (slot != last)
                    begin
                        rec_a[slot] = rec_a[last];
                        rec_b[slot] = rec_b[last];
                        slot_owner[slot] = slot_owner[last];
                        id_slot[slot_owner[last]] = s;
                    end
                    id_slot[r.obj_id] = '0;
                    live_cnt--;
                end
                else
                begin
                    if (r.req_type == REQ_WRITE)
                    begin
                        if (r.field_sel == FIELD_A)
                            rec_a[slot] = r.value;
                        else
                            rec_b[slot] = r.value;
                    end
                    o.a_value = rec_a[slot];
                    o.b_value = rec_b[slot];
                end
            end
        end
        o.live_count = live_cnt;
        return o;
    endfunction

    function automatic req_t mk(logic [1:0] kind, logic [9:0] id, logic sel,
                                logic signed [31:0] val);
        req_t r;
        r.req_type  = kind;
        r.obj_id    = id;
        r.field_sel = sel;
        r.value     = val;
        return r;
    endfunction

    function automatic rsp_t rs(logic [1:0] st, logic [9:0] nid, logic signed [31:0] a,
                                logic signed [31:0] b, logic [8:0] cnt);
        rsp_t o;
        o.status     = st;
        o.new_id     = nid;
        o.a_value    = a;
        o.b_value    = b;
        o.live_count = cnt;
        return o;
    endfunction

    // mostly short gaps, a few long ones, and runs with none
    function automatic int pick_gap();
        int p;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) >= 12)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return -32'sd1;
        endcase
    endfunction

    // a live id with chance live_pct, else an old or arbitrary one
    function automatic logic [9:0] pick_target(int live_pct);
        if (live_cnt > 0 && $urandom_range(0, 99) < live_pct)
            return slot_owner[8'($urandom_range(0, live_cnt - 1))];
        if (next_id > 0 && $urandom_range(0, 1) == 1)
            return 10'($urandom_range(0, next_id - 1));
        return 10'($urandom_range(0, NUM_IDS - 1));
    endfunction

    // drive one request beat and wait until it is taken
    task automatic send_beat(req_t r, bit typed, rsp_t want);
        int          gap;
        rsp_t        p;
        logic [63:0] junk;
        gap = pick_gap();
        if (gap > 0)
        begin
            junk = {$urandom, $urandom};
            start <= 1'b0;
            req   <= junk[$bits(req_t)-1:0];
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        p = table_update(r);
        awaited_rsp_q.push_back(typed ? want : p);
    endtask

    task automatic send_rand(logic [1:0] kind, int live_pct);
        req_t r;
        r = mk(kind, pick_target(live_pct), 1'($urandom), pick_value());
        send_beat(r, 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk)
    begin : rsp_check
        rsp_t w;
        if (rst_n && done)
        begin
            if (awaited_rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: st=%0d id=%0d a=%0d b=%0d cnt=%0d",
                             rsp.status, rsp.new_id, rsp.a_value, rsp.b_value,
                             rsp.live_count);
            end
            else
            begin
                w = awaited_rsp_q.pop_front();
                if (w.status !== rsp.status || w.new_id !== rsp.new_id ||
                    w.a_value !== rsp.a_value || w.b_value !== rsp.b_value ||
                    w.live_count !== rsp.live_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp st=%0d id=%0d a=%0d b=%0d cnt=%0d, %s",
                                 $realtime, w.status, w.new_id, w.a_value, w.b_value,
                                 w.live_count,
                                 $sformatf("got st=%0d id=%0d a=%0d b=%0d cnt=%0d",
                                           rsp.status, rsp.new_id, rsp.a_value,
                                           rsp.b_value, rsp.live_count));
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        row_t plan [25];
        req_t r;
        mix_t mix;
        int   mix_left;
        int   i;
        int   p;
        int   c_lim;
        int   d_lim;

        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        mismatches = 0;
        burst_left = 0;
        mix_left   = 0;
        mix        = MIX_FILL;

        // directed rows: lookups on an empty table, swap and last-record removal
        plan[0]  = '{mk(REQ_READ, 10'd0, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd0)};
        plan[1]  = '{mk(REQ_DESTROY, 10'd1023, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd0)};
        plan[2]  = '{mk(REQ_WRITE, 10'd5, FIELD_B, 1), 1, rs(ST_DEAD, 0, 0, 0, 9'd0)};
        plan[3]  = '{mk(REQ_CREATE, 10'd0, FIELD_A, 0), 1, rs(ST_OK, 10'd0, 0, 0, 9'd1)};
        plan[4]  = '{mk(REQ_CREATE, 10'd1023, FIELD_B, -1), 1, rs(ST_OK, 10'd1, 0, 0, 9'd2)};
        plan[5]  = '{mk(REQ_CREATE, 10'd0, FIELD_A, 0), 1, rs(ST_OK, 10'd2, 0, 0, 9'd3)};
        plan[6]  = '{mk(REQ_READ, 10'd0, FIELD_A, 0), 1, rs(ST_OK, 0, 0, 0, 9'd3)};
        plan[7]  = '{mk(REQ_WRITE, 10'd0, FIELD_A, 32'sh7FFF_FFFF), 1,
                     rs(ST_OK, 0, 32'sh7FFF_FFFF, 0, 9'd3)};
        plan[8]  = '{mk(REQ_WRITE, 10'd0, FIELD_B, 32'sh8000_0000), 1,
                     rs(ST_OK, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 9'd3)};
        plan[9]  = '{mk(REQ_WRITE, 10'd2, FIELD_A, -32'sd1), 0, '0};
        plan[10] = '{mk(REQ_WRITE, 10'd2, FIELD_B, 32'sh5A5A_5A5A), 0, '0};
        plan[11] = '{mk(REQ_READ, 10'd3, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd3)};
        plan[12] = '{mk(REQ_DESTROY, 10'd0, FIELD_A, 0), 1, rs(ST_OK, 0, 0, 0, 9'd2)};
        plan[13] = '{mk(REQ_READ, 10'd2, FIELD_A, 0), 0, '0};
        plan[14] = '{mk(REQ_READ, 10'd0, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd2)};
        plan[15] = '{mk(REQ_DESTROY, 10'd0, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd2)};
        plan[16] = '{mk(REQ_DESTROY, 10'd1, FIELD_A, 0), 1, rs(ST_OK, 0, 0, 0, 9'd1)};
        plan[17] = '{mk(REQ_READ, 10'd1, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd1)};
        plan[18] = '{mk(REQ_WRITE, 10'd2, FIELD_A, 0), 0, '0};
        plan[19] = '{mk(REQ_DESTROY, 10'd2, FIELD_B, 0), 1, rs(ST_OK, 0, 0, 0, 9'd0)};
        plan[20] = '{mk(REQ_CREATE, 10'd0, FIELD_A, 0), 1, rs(ST_OK, 10'd3, 0, 0, 9'd1)};
        plan[21] = '{mk(REQ_WRITE, 10'd1023, FIELD_B, 32'sd12345), 1,
                     rs(ST_DEAD, 0, 0, 0, 9'd1)};
        plan[22] = '{mk(REQ_READ, 10'd3, FIELD_B, 0), 1, rs(ST_OK, 0, 0, 0, 9'd1)};
        plan[23] = '{mk(REQ_READ, 10'h2AA, FIELD_A, 0), 1, rs(ST_DEAD, 0, 0, 0, 9'd1)};
        plan[24] = '{mk(REQ_DESTROY, 10'd3, FIELD_A, 0), 1, rs(ST_OK, 0, 0, 0, 9'd0)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_beat(plan[k].stim, plan[k].typed, plan[k].want);

        // random traffic in episodes that fill, churn or drain the store
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (mix_left == 0)
            begin
                mix      = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(40, 120);
            end
            mix_left--;
            case (mix)
                MIX_FILL:  begin c_lim = 60; d_lim = 70; end
                MIX_CHURN: begin c_lim = 25; d_lim = 45; end
                default:   begin c_lim = 10; d_lim = 60; end
            endcase
            p = $urandom_range(0, 99);
            if (p < c_lim)
                send_rand(REQ_CREATE, 85);
            else if (p < d_lim)
                send_rand(REQ_DESTROY, 85);
            else if (p[0])
                send_rand(REQ_READ, 85);
            else
                send_rand(REQ_WRITE, 85);
        end

        // use up every id, bouncing off a full store on the way
        while (next_id < NUM_IDS)
        begin
            if (live_cnt == NUM_SLOTS)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_rand(REQ_CREATE, 0);
                else
                    send_rand(REQ_DESTROY, 100);
            end
            else if ($urandom_range(0, 9) < 8)
                send_rand(REQ_CREATE, 0);
            else
                send_rand($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 90);
        end

        // ids exhausted, store likely full: exhaustion must win
        send_rand(REQ_CREATE, 0);
        send_rand(REQ_CREATE, 0);
        send_rand(REQ_DESTROY, 100);
        send_rand(REQ_CREATE, 0);

        // drain everything with some stray lookups mixed in
        while (live_cnt > 0)
        begin
            p = $urandom_range(0, 9);
            if (p < 7)
                send_rand(REQ_DESTROY, 100);
            else
                send_rand(p[0] ? REQ_READ : REQ_WRITE, 60);
        end
        send_rand(REQ_CREATE, 0);
        send_rand(REQ_READ, 0);
        start <= 1'b0;

        // let the last results come back
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && awaited_rsp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
